/* src/slr_pkg.sv */
// Shared types and constants for the styled line rasterizer.
// No dependencies; imported by slr_stepper and styled_line_rasterizer.
package slr_pkg;

  localparam int PATTERN_BITS  = 16;
  localparam int DASH_IDX_BITS = $clog2(PATTERN_BITS);
  localparam int COLOR_BITS    = 32;

  typedef logic [PATTERN_BITS-1:0]  pattern_t;
  typedef logic [DASH_IDX_BITS-1:0] dash_idx_t;
  typedef logic [COLOR_BITS-1:0]    color_t;

  // Item kind codes.
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  // Control part of one pixel result handed from the stepper to the output stage.
  typedef struct packed {
    logic valid;
    logic plot;
    logic last;
  } res_ctl_t;

endpackage

/* src/styled_line_rasterizer.sv */
// Top level of the styled line rasterizer: input register, stepper and output register.
// Depends on slr_pkg and slr_stepper.
//
// Usage: the input channel (in_valid / in_stall) carries one transaction per item.
// A start transaction (in_kind = start) loads both endpoints, the 16-bit dash pattern
// and the color; it produces no output. Each step transaction then yields one pixel
// on the output channel (out_valid / out_stall) with its coordinates, the plot flag
// taken from the pattern MSB first and the line color. A line yields
// max(|dx|,|dy|)+1 pixels; the final one sits on the second endpoint with out_last
// set, after which the block is idle. A step while idle is dropped silently, and a
// start during a line abandons the old line.
// A step transaction is taken into the input register, and its pixel is captured in the output
// register once that register can advance, because the input register feeds the Bresenham
// update straight into the output register. The input channel takes one transaction per
// cycle while the receiver does not stall the output, since the stepper handles each item
// in a single-pass error-term update.
// Reset (rst_n low, synchronous) empties both registers and leaves no line active.
// When the receiver stalls a pending pixel, the output register holds it; the input
// register still takes one further transaction, and in_stall rises only once that
// register is also full behind the stalled output.
module styled_line_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  input  slr_pkg::pattern_t     in_pattern,
  input  slr_pkg::color_t       in_color,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_plot,
  output slr_pkg::color_t       out_pixel_color,
  output logic                  out_last
);
  import slr_pkg::*;

  // Input register holding one accepted transaction.
  logic                  item_valid_r;
  kind_t                 kind_r;
  logic [COORD_BITS-1:0] x_start_r, y_start_r, x_end_r, y_end_r;
  pattern_t              pattern_r;
  color_t                color_r;

  // Output register.
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] pix_x_r, pix_y_r;
  logic                  plot_r, last_r;
  color_t                pix_color_r;

  res_ctl_t              res_ctl;
  logic [COORD_BITS-1:0] res_x, res_y;
  color_t                res_color;
  logic                  adv;
  logic                  go;

  // The output register can take a new pixel when it is empty or being drained.
  assign adv      = !out_valid_r || !out_stall;
  assign go       = item_valid_r && adv;
  assign in_stall = item_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_r    <= kind_t'(in_kind);
      x_start_r <= in_x_start;
      y_start_r <= in_y_start;
      x_end_r   <= in_x_end;
      y_end_r   <= in_y_end;
      pattern_r <= in_pattern;
      color_r   <= in_color;
    end
  end

  slr_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .kind      (kind_r),
    .x_start   (x_start_r),
    .y_start   (y_start_r),
    .x_end     (x_end_r),
    .y_end     (y_end_r),
    .pattern   (pattern_r),
    .color     (color_r),
    .res_ctl   (res_ctl),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_color (res_color)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_ctl.valid;
    end
  end

  // A pixel is only produced when go is high, which implies adv.
  always_ff @(posedge clk) begin
    if (res_ctl.valid) begin
      pix_x_r     <= res_x;
      pix_y_r     <= res_y;
      plot_r      <= res_ctl.plot;
      last_r      <= res_ctl.last;
      pix_color_r <= res_color;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_plot        = plot_r;
  assign out_pixel_color = pix_color_r;
  assign out_last        = last_r;

endmodule

/* src/slr_stepper.sv */
// Line state registers and the single-pass Bresenham update for one item.
// Depends on slr_pkg for the kind codes, pattern/color types and result struct.
module slr_stepper #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  slr_pkg::kind_t         kind,
  input  logic [COORD_BITS-1:0]  x_start,
  input  logic [COORD_BITS-1:0]  y_start,
  input  logic [COORD_BITS-1:0]  x_end,
  input  logic [COORD_BITS-1:0]  y_end,
  input  slr_pkg::pattern_t      pattern,
  input  slr_pkg::color_t        color,
  output slr_pkg::res_ctl_t      res_ctl,
  output logic [COORD_BITS-1:0]  res_x,
  output logic [COORD_BITS-1:0]  res_y,
  output slr_pkg::color_t        res_color
);
  import slr_pkg::*;

  localparam int DW = COORD_BITS + 1;  // deltas and pixel count
  localparam int EW = COORD_BITS + 3;  // error term, signed

  logic                  active_r, active_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  logic [EW-1:0]         err_r, err_nxt;
  logic [DW-1:0]         maj_r, maj_nxt, min_r, min_nxt;
  logic                  neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic                  y_major_r, y_major_nxt;
  logic [DW-1:0]         left_r, left_nxt;
  pattern_t              pat_r, pat_nxt;
  dash_idx_t             idx_r, idx_nxt;
  color_t                color_r, color_nxt;

  logic [DW-1:0] dx, dy, adx, ady;
  logic          y_maj_new;
  logic [DW-1:0] maj_new, min_new;
  logic          is_last, err_nonneg, step_x, step_y;
  logic [EW-1:0] maj2, min2;

  // Start of line: deltas, octant and initial error term.
  always_comb begin
    dx = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
    dy = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
    adx = dx[DW-1] ? (~dx + 1'b1) : dx;
    ady = dy[DW-1] ? (~dy + 1'b1) : dy;
    y_maj_new = (ady > adx);
    maj_new = y_maj_new ? ady : adx;
    min_new = y_maj_new ? adx : ady;
  end

  // Pixel step: the minor axis moves when the error term is not negative.
  always_comb begin
    is_last    = (left_r <= DW'(1));
    err_nonneg = ~err_r[EW-1];
    maj2       = {1'b0, maj_r, 1'b0};
    min2       = {1'b0, min_r, 1'b0};
    step_x     = y_major_r ? err_nonneg : 1'b1;
    step_y     = y_major_r ? 1'b1 : err_nonneg;
  end

  always_comb begin
    active_nxt  = active_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    end_x_nxt   = end_x_r;
    end_y_nxt   = end_y_r;
    err_nxt     = err_r;
    maj_nxt     = maj_r;
    min_nxt     = min_r;
    neg_x_nxt   = neg_x_r;
    neg_y_nxt   = neg_y_r;
    y_major_nxt = y_major_r;
    left_nxt    = left_r;
    pat_nxt     = pat_r;
    idx_nxt     = idx_r;
    color_nxt   = color_r;

    if (go && kind == KIND_START) begin
      active_nxt  = 1'b1;
      cur_x_nxt   = x_start;
      cur_y_nxt   = y_start;
      end_x_nxt   = x_end;
      end_y_nxt   = y_end;
      neg_x_nxt   = dx[DW-1] || (dx == '0);
      neg_y_nxt   = dy[DW-1] || (dy == '0);
      y_major_nxt = y_maj_new;
      maj_nxt     = maj_new;
      min_nxt     = min_new;
      err_nxt     = {1'b0, min_new, 1'b0} - {2'b00, maj_new};
      left_nxt    = maj_new + 1'b1;
      pat_nxt     = pattern;
      idx_nxt     = '0;
      color_nxt   = color;
    end else if (go && active_r) begin
      if (is_last) begin
        active_nxt = 1'b0;
        left_nxt   = '0;
      end else begin
        idx_nxt  = idx_r + 1'b1;
        left_nxt = left_r - 1'b1;
        err_nxt  = err_r + min2 - (err_nonneg ? maj2 : '0);
        if (step_x) begin
          cur_x_nxt = neg_x_r ? (cur_x_r - 1'b1) : (cur_x_r + 1'b1);
        end
        if (step_y) begin
          cur_y_nxt = neg_y_r ? (cur_y_r - 1'b1) : (cur_y_r + 1'b1);
        end
      end
    end
  end

  // Result of a step item; the pattern is read MSB first (bit index is ~idx).
  always_comb begin
    res_ctl.valid = go && (kind == KIND_STEP) && active_r;
    res_ctl.plot  = pat_r[~idx_r];
    res_ctl.last  = is_last;
    res_x         = is_last ? end_x_r : cur_x_r;
    res_y         = is_last ? end_y_r : cur_y_r;
    res_color     = color_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
      err_r     <= '0;
      maj_r     <= '0;
      min_r     <= '0;
      neg_x_r   <= 1'b0;
      neg_y_r   <= 1'b0;
      y_major_r <= 1'b0;
      left_r    <= '0;
      pat_r     <= '0;
      idx_r     <= '0;
      color_r   <= '0;
    end else begin
      active_r  <= active_nxt;
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      end_x_r   <= end_x_nxt;
      end_y_r   <= end_y_nxt;
      err_r     <= err_nxt;
      maj_r     <= maj_nxt;
      min_r     <= min_nxt;
      neg_x_r   <= neg_x_nxt;
      neg_y_r   <= neg_y_nxt;
      y_major_r <= y_major_nxt;
      left_r    <= left_nxt;
      pat_r     <= pat_nxt;
      idx_r     <= idx_nxt;
      color_r   <= color_nxt;
    end
  end

endmodule

/* tb/sv/styled_line_rasterizer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the styled line rasterizer: directed and random lines with
// random idling on both channels. Depends on slr_pkg and styled_line_rasterizer.
module styled_line_rasterizer_test;
  import slr_pkg::*;

  localparam int COORD_BITS     = 16;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int MAX_IDLE       = 13;
  localparam int HOLD_OFF       = 60;
  // Leave a little margin after the last pixel.
  localparam int DRAIN_CYCLES   = 8;
  // Longest correct quiet spell is a sender gap plus the long receiver hold-off.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One pixel as it should leave the block.
  typedef struct {
    coord_t x;
    coord_t y;
    logic   plot;
    color_t color;
    logic   last;
  } pixel_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  logic      in_kind = KIND_START;
  coord_t    in_x_start = '0;
  coord_t    in_y_start = '0;
  coord_t    in_x_end = '0;
  coord_t    in_y_end = '0;
  pattern_t  in_pattern = '0;
  color_t    in_color = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  coord_t    out_pixel_x;
  coord_t    out_pixel_y;
  logic      out_plot;
  color_t    out_pixel_color;
  logic      out_last;

  // Pixels that the accepted transactions must still produce, oldest first.
  pixel_t pending_pixels[$];
  int     mismatches = 0;
  // Starts and steps of an active line; steps that the block drops are not counted.
  int     line_items = 0;
  int     idle_count = 0;

  // Idling controls shared by the test tasks, the sender and the receiver.
  bit     send_quiet = 1'b0;
  bit     recv_quiet = 1'b0;
  int     hold_request = 0;

  // Mirror of the line state inside the block.
  logic              line_active = 1'b0;
  coord_t            pos_x, pos_y, stop_x, stop_y;
  logic signed [18:0] bres_err;
  logic [16:0]       major_d, minor_d;
  logic              x_neg, y_neg, y_major;
  logic [16:0]       pixels_left;
  pattern_t          dash;
  dash_idx_t         dash_pos;
  color_t            line_col;

  styled_line_rasterizer #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_pattern     (in_pattern),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_plot       (out_plot),
    .out_pixel_color(out_pixel_color),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Number of cycles to idle before the next transaction. At least a third of the draws are
  // zero so that back-to-back runs appear even when idling is on.
  function automatic int idle_gap(input bit quiet);
    if (quiet) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Bresenham stepper with the dash pattern. A start loads the line and produces nothing.
  // A step on an active line yields one pixel: the current position and pattern bit, or the
  // endpoint with last set once only one pixel is left. A step with no line is dropped.
  task automatic track_line_item(input kind_t kind, input coord_t xs, input coord_t ys,
                                 input coord_t xe, input coord_t ye, input pattern_t pat,
                                 input color_t col);
    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    pixel_t             px;
    if (kind == KIND_START) begin
      // Differences need one extra bit so the extreme endpoints cannot overflow.
      dx = {xe[COORD_BITS-1], xe} - {xs[COORD_BITS-1], xs};
      dy = {ye[COORD_BITS-1], ye} - {ys[COORD_BITS-1], ys};
      // A zero delta counts as negative; it never matters since that axis never moves.
      x_neg = dx[16] || (dx == 0);
      y_neg = dy[16] || (dy == 0);
      adx = dx[16] ? -dx : dx;
      ady = dy[16] ? -dy : dy;
      // Ties between the axes go to x.
      y_major = ady > adx;
      major_d = y_major ? ady : adx;
      minor_d = y_major ? adx : ady;
      bres_err = {1'b0, minor_d, 1'b0} - {2'b00, major_d};
      pos_x = xs;
      pos_y = ys;
      stop_x = xe;
      stop_y = ye;
      pixels_left = major_d + 17'd1;
      dash = pat;
      dash_pos = '0;
      line_col = col;
      line_active = 1'b1;
      line_items++;
    end else if (line_active) begin
      px.plot = dash[PATTERN_BITS - 1 - dash_pos];
      px.color = line_col;
      if (pixels_left <= 17'd1) begin
        // The final pixel is placed on the endpoint itself and closes the line.
        px.x = stop_x;
        px.y = stop_y;
        px.last = 1'b1;
        line_active = 1'b0;
        pixels_left = '0;
      end else begin
        px.x = pos_x;
        px.y = pos_y;
        px.last = 1'b0;
        dash_pos = dash_pos + 1'b1;
        if (!bres_err[18]) begin
          if (y_major) pos_x = x_neg ? pos_x - 16'd1 : pos_x + 16'd1;
          else pos_y = y_neg ? pos_y - 16'd1 : pos_y + 16'd1;
          bres_err = bres_err - {1'b0, major_d, 1'b0};
        end
        if (y_major) pos_y = y_neg ? pos_y - 16'd1 : pos_y + 16'd1;
        else pos_x = x_neg ? pos_x - 16'd1 : pos_x + 16'd1;
        bres_err = bres_err + {1'b0, minor_d, 1'b0};
        pixels_left = pixels_left - 17'd1;
      end
      pending_pixels.push_back(px);
      line_items++;
    end
  endtask

  // Offers one transaction after a random gap and holds it until the block takes it.
  // Valid is only lowered when a gap follows, so a back-to-back run keeps it high.
  task automatic send_item(input kind_t kind, input coord_t xs, input coord_t ys,
                           input coord_t xe, input coord_t ye, input pattern_t pat,
                           input color_t col);
    int gap;
    gap = idle_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end <= xe;
    in_y_end <= ye;
    in_pattern <= pat;
    in_color <= col;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    track_line_item(kind, xs, ys, xe, ye, pat, col);
  endtask

  // A step carries random junk in every other field, which the block must ignore.
  task automatic send_step();
    send_item(KIND_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), pattern_t'($urandom), $urandom);
  endtask

  // Receiver: stalls for a random number of cycles before each pixel. A hold-off request
  // from a test replaces the next draw, and is picked up even while no pixel is waiting.
  initial begin : receiver
    int n;
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = idle_gap(recv_quiet);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1 && hold_request == 0) @(posedge clk);
    end
  end

  // Every accepted pixel is compared with the oldest one still expected.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel at (%0d, %0d)", $signed(out_pixel_x), $signed(out_pixel_y));
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", $signed(want.x), $signed(out_pixel_x));
          mismatches++;
        end
        if (out_pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", $signed(want.y), $signed(out_pixel_y));
          mismatches++;
        end
        if (out_plot !== want.plot) begin
          $error("plot: expected %0b, got %0b", want.plot, out_plot);
          mismatches++;
        end
        if (out_pixel_color !== want.color) begin
          $error("pixel_color: expected %08h, got %08h", want.color, out_pixel_color);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a long spell with no transaction on either channel means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Steps straight after reset find no line and must be dropped.
  task automatic test_idle_step();
    send_step();
    send_step();
  endtask

  // A line whose endpoints coincide yields just the endpoint, with the top pattern bit and
  // last set; the step after it finds the block idle again.
  task automatic test_single_point();
    send_item(KIND_START, 16'sd5, -16'sd7, 16'sd5, -16'sd7, 16'h8000, 32'h1234_5678);
    send_step();
    send_step();
  endtask

  // Full-range diagonals in both directions with all-ones and all-zeros pattern and color.
  // Each is cut short by the next start, which must drop the old line cleanly.
  task automatic test_extreme_fields();
    send_item(KIND_START, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff, 32'hffff_ffff);
    send_step();
    send_step();
    send_item(KIND_START, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h0000, 32'h0000_0000);
    send_step();
    send_step();
  endtask

  // A horizontal line run toward negative x and a vertical line run toward positive y.
  task automatic test_axis_lines();
    send_item(KIND_START, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'ha5a5, 32'hdead_beef);
    repeat (4) send_step();
    send_item(KIND_START, 16'sd0, -16'sd2, 16'sd0, 16'sd1, 16'h5a5a, 32'h0bad_f00d);
    repeat (4) send_step();
  endtask

  // The receiver holds off for a long stretch while steps keep coming back to back, so
  // both registers in the block fill up and the input stalls before the pixels drain.
  task automatic test_backpressure();
    send_quiet = 1'b1;
    recv_quiet = 1'b0;
    hold_request = HOLD_OFF;
    send_item(KIND_START, 16'sd0, 16'sd0, 16'sd30, 16'sd10, 16'hf0f0, 32'hcafe_0001);
    while (line_active) send_step();
    send_quiet = 1'b0;
  endtask

  // Random lines. Most are short and stepped to the end; some are long, some end early and
  // are dropped by the next start, and some have far-apart endpoints. Stray steps between
  // lines add noise, and some lines run with no idling on one or both sides.
  task automatic test_random_lines();
    int     sel, span, cap, n;
    coord_t xs, ys, xe, ye;
    while (line_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_step();
      end
      xs = coord_t'($urandom);
      ys = coord_t'($urandom);
      if (sel == 0) begin
        xe = coord_t'($urandom);
        ye = coord_t'($urandom);
        cap = $urandom_range(0, 20);
      end else begin
        span = (sel <= 2) ? 300 : 12;
        xe = xs + coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
        ye = ys + coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
        cap = (sel == 3) ? $urandom_range(0, 5) : 1000;
      end
      send_item(KIND_START, xs, ys, xe, ye, pattern_t'($urandom), $urandom);
      n = 0;
      while (line_active && n < cap) begin
        send_step();
        n++;
      end
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_step();
    test_single_point();
    test_extreme_fields();
    test_axis_lines();
    test_backpressure();
    test_random_lines();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
